// ===== rtl/core/bpd_pkg.sv =====
// ----------------------------------------------------------------------------
// Breath phase detector package
// Shared constants: window size, configuration register indexes and event
// codes used by the detector and its port checker.
// ----------------------------------------------------------------------------
package bpd_pkg;

  localparam int unsigned BPD_WINDOW = 8;

  localparam int unsigned FLOW_W  = 16;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned MCNT_W  = 7;
  localparam int unsigned PER_W   = 8;
  localparam int unsigned EVENT_W = 2;

  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INSP_THR   = 4'd0,
    REG_EXP_THR    = 4'd1,
    REG_MIN_COUNT  = 4'd2,
    REG_SAMPLE_PER = 4'd3
  } cfg_reg_e;

  typedef enum logic [EVENT_W-1:0] {
    EV_NONE      = 2'd0,
    EV_INSP_START = 2'd1,
    EV_INSP_END   = 2'd2
  } event_e;

  localparam logic signed [FLOW_W-1:0] INSP_THR_RST   = 16'sd200;
  localparam logic signed [FLOW_W-1:0] EXP_THR_RST    = -16'sd200;
  localparam logic [MCNT_W-1:0]        MIN_COUNT_RST  = 7'd4;
  localparam logic [PER_W-1:0]         SAMPLE_PER_RST = 8'd10;

endpackage

// ===== rtl/core/breath_phase_detector.sv =====
// Each accepted item is followed by a window scan, which reads one sample
// per cycle from the memory, then by the calc and done states; the input
// stalls until the result is passed on, so no new item enters meanwhile.
// Reset: control and config registers return to defaults, the flag clears;
// all window entries read as zero via per-entry valid bits; no clearing pass.
// ----------------------------------------------------------------------------
// Breath phase detector
// Keeps the recent flow samples in a circular buffer memory, scans it after
// each item for samples past the active threshold and reports back-dated
// start and end events of inspiration.
// ----------------------------------------------------------------------------
module breath_phase_detector
  import bpd_pkg::*;
#(
  parameter int unsigned WINDOW = BPD_WINDOW
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration write channel
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [CFG_DATA_W-1:0]    cfg_data_i,
  // input channel
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [FLOW_W-1:0] flow_i,
  input  logic [TIME_W-1:0]        now_ms_i,
  // output channel
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     insp_active_o,
  output logic [EVENT_W-1:0]       event_res_o,
  output logic [TIME_W-1:0]        event_time_ms_o,
  output logic [TIME_W-1:0]        insp_length_ms_o
);

  localparam int unsigned ADDR_W = $clog2(WINDOW);
  localparam int unsigned CNT_W  = $clog2(WINDOW + 1);
  localparam int unsigned PROD_W = ADDR_W + PER_W;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(WINDOW - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_CALC = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  // configuration registers
  logic signed [FLOW_W-1:0] insp_thr_q, exp_thr_q;
  logic [MCNT_W-1:0]        min_count_q;
  logic [PER_W-1:0]         period_q;

  // control state
  logic [1:0]        state_q, state_d;
  logic [ADDR_W-1:0] wp_q;
  logic [ADDR_W-1:0] raddr_q;
  logic [ADDR_W-1:0] iss_age_q;
  logic              iss_act_q;
  logic              rd_pend_q;
  logic [ADDR_W-1:0] rd_age_q;
  logic [WINDOW-1:0] vld_q;
  logic              insp_flag_q;
  logic [TIME_W-1:0] start_time_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [ADDR_W-1:0] oldest_q;
  logic              out_valid_q;

  // window memory and read path
  logic signed [FLOW_W-1:0] mem_q [WINDOW];
  logic signed [FLOW_W-1:0] rdata_q;
  logic                     rvld_q;

  // item payload and intermediate results
  logic [TIME_W-1:0] now_q;
  logic              hit_q;
  logic [TIME_W-1:0] ev_time_q;

  // output payload
  logic              insp_active_q;
  logic [EVENT_W-1:0] event_res_q;
  logic [TIME_W-1:0] event_time_q;
  logic [TIME_W-1:0] insp_len_q;

  logic                     in_acc;
  logic                     rd_en;
  logic signed [FLOW_W-1:0] sample;
  logic                     samp_hit;
  logic [MCNT_W-1:0]        need;
  logic [PROD_W-1:0]        backdate;
  logic                     out_free;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign rd_en       = (state_q == ST_SCAN) && iss_act_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  // An entry never written since reset reads as zero.
  assign sample   = rvld_q ? rdata_q : '0;
  assign samp_hit = insp_flag_q ? (sample <= exp_thr_q) : (sample >= insp_thr_q);
  assign need     = (min_count_q == '0) ? MCNT_W'(1) : min_count_q;
  assign backdate = PROD_W'(oldest_q) * PROD_W'(period_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      insp_thr_q  <= INSP_THR_RST;
      exp_thr_q   <= EXP_THR_RST;
      min_count_q <= MIN_COUNT_RST;
      period_q    <= SAMPLE_PER_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_INSP_THR:   insp_thr_q  <= cfg_data_i[FLOW_W-1:0];
        REG_EXP_THR:    exp_thr_q   <= cfg_data_i[FLOW_W-1:0];
        REG_MIN_COUNT:  min_count_q <= cfg_data_i[MCNT_W-1:0];
        REG_SAMPLE_PER: period_q    <= cfg_data_i[PER_W-1:0];
        default: ;
      endcase
    end
  end

  // Window memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mem_q[wp_q] <= flow_i;
    end
    if (rd_en) begin
      rdata_q <= mem_q[raddr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (in_acc) begin
        vld_q[wp_q] <= 1'b1;
      end
      if (rd_en) begin
        rvld_q <= vld_q[raddr_q];
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_SCAN;
      ST_SCAN: if (rd_pend_q && (rd_age_q == LAST_ADDR)) state_d = ST_CALC;
      ST_CALC: state_d = ST_DONE;
      ST_DONE: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      wp_q         <= '0;
      raddr_q      <= '0;
      iss_age_q    <= '0;
      iss_act_q    <= 1'b0;
      rd_pend_q    <= 1'b0;
      rd_age_q     <= '0;
      cnt_q        <= '0;
      oldest_q     <= '0;
      insp_flag_q  <= 1'b0;
      start_time_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;

      if (in_acc) begin
        // The newest sample sits at wp_q; the scan walks back from there.
        raddr_q   <= wp_q;
        wp_q      <= (wp_q == LAST_ADDR) ? '0 : wp_q + ADDR_W'(1);
        iss_age_q <= '0;
        iss_act_q <= 1'b1;
        cnt_q     <= '0;
        oldest_q  <= '0;
      end else if (rd_en) begin
        raddr_q <= (raddr_q == '0) ? LAST_ADDR : raddr_q - ADDR_W'(1);
        if (iss_age_q == LAST_ADDR) begin
          iss_act_q <= 1'b0;
        end else begin
          iss_age_q <= iss_age_q + ADDR_W'(1);
        end
      end

      rd_pend_q <= rd_en;
      rd_age_q  <= iss_age_q;

      // Ages arrive in increasing order, so the last hit is the oldest one.
      if (rd_pend_q && samp_hit) begin
        cnt_q    <= cnt_q + CNT_W'(1);
        oldest_q <= rd_age_q;
      end

      if ((state_q == ST_DONE) && out_free) begin
        out_valid_q <= 1'b1;
        if (hit_q) begin
          insp_flag_q <= !insp_flag_q;
          if (!insp_flag_q) begin
            start_time_q <= ev_time_q;
          end
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      now_q <= now_ms_i;
    end
    if (state_q == ST_CALC) begin
      hit_q     <= (8'(cnt_q) >= 8'(need));
      ev_time_q <= now_q - TIME_W'(backdate);
    end
    if ((state_q == ST_DONE) && out_free) begin
      insp_active_q <= hit_q ? !insp_flag_q : insp_flag_q;
      if (!hit_q) begin
        event_res_q  <= EV_NONE;
        event_time_q <= '0;
        insp_len_q   <= '0;
      end else if (!insp_flag_q) begin
        event_res_q  <= EV_INSP_START;
        event_time_q <= ev_time_q;
        insp_len_q   <= '0;
      end else begin
        event_res_q  <= EV_INSP_END;
        event_time_q <= ev_time_q;
        insp_len_q   <= ev_time_q - start_time_q;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign insp_active_o    = insp_active_q;
  assign event_res_o      = event_res_q;
  assign event_time_ms_o  = event_time_q;
  assign insp_length_ms_o = insp_len_q;

endmodule

// ===== rtl/core/bpd_chk.sv =====
// ----------------------------------------------------------------------------
// Breath phase detector port checker
// Watches the detector's ports for handshake and event consistency.
// ----------------------------------------------------------------------------
module bpd_chk
  import bpd_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic               insp_active_o,
  input logic [EVENT_W-1:0] event_res_o,
  input logic [TIME_W-1:0]  event_time_ms_o,
  input logic [TIME_W-1:0]  insp_length_ms_o
);

  // A result waiting on a stalled consumer holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(event_res_o) &&
    $stable(event_time_ms_o) && $stable(insp_length_ms_o) && $stable(insp_active_o))
    else $error("stalled result changed");

  // Only one item is worked on at a time.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while an item is in progress");

  // A start leaves inspiration active, an end leaves it inactive.
  a_event_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (event_res_o == EV_NONE) ||
    ((event_res_o == EV_INSP_START) && insp_active_o) ||
    ((event_res_o == EV_INSP_END) && !insp_active_o))
    else $error("event code inconsistent with phase");

  // Length is reported only on an end event, time only on an event.
  a_quiet_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_res_o != EV_INSP_END) |-> (insp_length_ms_o == '0) &&
    ((event_res_o != EV_NONE) || (event_time_ms_o == '0)))
    else $error("length or time set without an event");

endmodule

bind breath_phase_detector bpd_chk u_bpd_chk (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .insp_active_o    (insp_active_o),
  .event_res_o      (event_res_o),
  .event_time_ms_o  (event_time_ms_o),
  .insp_length_ms_o (insp_length_ms_o)
);
